>>> src/spq_pkg.sv
// Package for the sorted priority queue: widths, codes, link and control types.
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int PRIO_W    = 16;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_NUDGE = 2'd2,
    CMD_CLR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic   load;   // capture match/greater flags against item
    logic   write;  // commit the update for cmd
    cmd_e   cmd;
    entry_t item;
  } ctrl_t;

  // Link passed from a cell to its right neighbor
  typedef struct packed {
    logic   rm;     // removal point at or left of this cell
    logic   ins;    // insertion point at or left of this cell
    entry_t rem;    // entry after removal shift
    entry_t cur;    // stored entry
  } fwd_t;

  // Link passed from a cell to its left neighbor
  typedef struct packed {
    entry_t cur;
    logic   gt;
    logic   match;
  } bwd_t;

endpackage
`default_nettype wire

>>> src/spq_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface spq_in_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_e              command;
  logic [ID_W-1:0]   item_id;
  logic [PRIO_W-1:0] item_priority;

  modport source (output valid, command, item_id, item_priority, input ready);
  modport sink   (input valid, command, item_id, item_priority, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic                 head_valid;
  logic [ID_W-1:0]      head_id;
  logic [OUT_CNT_W-1:0] entry_count;

  modport source (output valid, status, head_valid, head_id, entry_count, input ready);
  modport sink   (input valid, status, head_valid, head_id, entry_count, output ready);
endinterface
`default_nettype wire

>>> src/spq_cell.sv
// One queue slot: holds an entry, compares it with the item, shifts with its neighbors.
`default_nettype none
module spq_cell import spq_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic          clk,
  input  wire ctrl_t         ctrl,
  input  wire logic [CW-1:0] cnt,       // occupancy before the command
  input  wire logic [CW-1:0] rcnt,      // occupancy after removal
  input  wire fwd_t          from_left,
  input  wire bwd_t          from_right,
  output fwd_t               to_right,
  output bwd_t               to_left,
  output logic [ID_W-1:0]    id_nxt,
  output logic               match
);

  entry_t entry_r, entry_nxt;
  logic   match_r, gt_r;
  logic   slot_valid;
  logic   rm, rg, ins;
  entry_t rem;

  assign slot_valid = CW'(IDX) < cnt;

  // Compare against the incoming item at accept
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      match_r <= slot_valid && (entry_r.id == ctrl.item.id);
      gt_r    <= slot_valid && ($signed(entry_r.prio) > $signed(ctrl.item.prio));
    end
  end

  // Removal shift: from the removal point on, take the right neighbor
  assign rm  = from_left.rm | match_r;
  assign rem = rm ? from_right.cur : entry_r;
  assign rg  = rm ? from_right.gt : gt_r;
  // Insertion point: first greater entry, or end of the shortened list
  assign ins = rg | (CW'(IDX) >= rcnt);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.cmd)
      CMD_ENQ: begin
        if (ins) entry_nxt = from_left.ins ? from_left.rem : ctrl.item;
        else     entry_nxt = rem;
      end
      CMD_DEQ: entry_nxt = rem;
      CMD_NUDGE: begin
        if (from_right.match) begin
          entry_nxt = '{id: from_right.cur.id, prio: entry_r.prio};
        end else if (match_r && (IDX != 0)) begin
          entry_nxt = from_left.cur;
        end
      end
      CMD_CLR: entry_nxt = entry_r;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) entry_r <= entry_nxt;
  end

  assign to_right = '{rm: rm, ins: ins, rem: rem, cur: entry_r};
  assign to_left  = '{cur: entry_r, gt: gt_r, match: match_r};
  assign id_nxt   = ctrl.write ? entry_nxt.id : entry_r.id;
  assign match    = match_r;

endmodule
`default_nettype wire

>>> src/sorted_priority_queue.sv
// Sorted priority queue: top level with sequencer, cell chain and result register.
// Usage:
//   Commands arrive on in_ch (enqueue, dequeue, nudge forward, clear) with an
//   id and a signed priority; each one yields exactly one result on out_ch
//   with a status, the head id with a valid flag and the entry count.
//   A transfer happens on a rising edge with valid and ready both high.
// Timing:
//   The accept edge latches the item and each cell compares it with its
//   entry; in the execute state, once out_ch is free, an edge shifts the
//   whole cell chain at once and loads the result register that drives
//   out_ch. No new command is taken until the sequencer is back in idle.
//   in_ch.ready is high while the sequencer is idle, also while a result
//   still waits on out_ch; the next command is compared meanwhile.
// Stall:
//   If out_ch is stalled, the pending command holds in its update cycle and
//   nothing in the queue changes until the waiting result is transferred.
// Reset:
//   rst_n low clears the count, the sequencer and out_ch.valid; the queue is
//   empty right after reset and no clearing pass is needed.
`default_nettype none
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  state_e            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt, rcnt;
  cmd_e              cmd_r;
  entry_t            item_r;
  ctrl_t             ctrl;
  logic              accept, fire, changes, found, full;
  status_e           status_nxt;
  logic [DEPTH-1:0]  match_vec;
  logic [ID_W-1:0]   head_nxt [DEPTH];
  fwd_t              fwd [DEPTH+1];
  bwd_t              bwd [DEPTH+1];
  logic [CW+OUT_CNT_W-1:0] cnt_ext;

  logic                 out_valid_r;
  status_e              status_r;
  logic                 head_valid_r;
  logic [ID_W-1:0]      head_id_r;
  logic [OUT_CNT_W-1:0] count_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    fire        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        fire = !out_valid_r || out_ch.ready;
        if (fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_ch.command;
      item_r <= '{id: in_ch.item_id, prio: in_ch.item_priority};
    end
  end

  // Decision on the latched compare flags
  assign found = |match_vec;
  assign full  = cnt_r == CW'(DEPTH);
  assign rcnt  = cnt_r - CW'(found);

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = STAT_OK;
    changes    = 1'b0;
    unique case (cmd_r)
      CMD_ENQ: begin
        if (found) begin
          changes = 1'b1;
        end else if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          changes = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      CMD_DEQ: begin
        if (cnt_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          changes = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      CMD_NUDGE: begin
        if (!found) status_nxt = STAT_NOT_FOUND;
        else        changes = 1'b1;
      end
      CMD_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Broadcast control
  assign ctrl.load  = accept;
  assign ctrl.write = fire && changes;
  assign ctrl.cmd   = cmd_r;
  assign ctrl.item  = (state_r == ST_IDLE) ?
                      entry_t'{id: in_ch.item_id, prio: in_ch.item_priority} : item_r;

  // Chain boundaries: dequeue removes from the front
  assign fwd[0]     = '{rm: (cmd_r == CMD_DEQ), ins: 1'b0, rem: '0, cur: '0};
  assign bwd[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cnt        (cnt_r),
      .rcnt       (rcnt),
      .from_left  (fwd[i]),
      .from_right (bwd[i+1]),
      .to_right   (fwd[i+1]),
      .to_left    (bwd[i]),
      .id_nxt     (head_nxt[i]),
      .match      (match_vec[i])
    );
  end

  // Count and result register
  assign cnt_ext = {{OUT_CNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) cnt_r <= cnt_nxt;
      if (fire)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r     <= status_nxt;
      head_valid_r <= cnt_nxt != '0;
      head_id_r    <= (cnt_nxt != '0) ? head_nxt[0] : '0;
      count_r      <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.head_valid  = head_valid_r;
  assign out_ch.head_id     = head_id_r;
  assign out_ch.entry_count = count_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_unique_id: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(match_vec))
    else $error("id held in more than one slot");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd_r != CMD_CLR) |=>
      (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CW'(1) ||
       cnt_r == $past(cnt_r) - CW'(1)))
    else $error("occupancy moved by more than one");

endmodule
`default_nettype wire
